@@ hdl/hce_pkg.sv @@
// Shared types and constants for the HTTP chunked transfer encoder.
// Used by the framer, the serialiser and the top level; depends on nothing.
package hce_pkg;

  localparam logic [15:0] MAX_CHUNK = 16'hffff;

  localparam logic [7:0] CR_BYTE   = 8'h0d;
  localparam logic [7:0] LF_BYTE   = 8'h0a;
  localparam logic [7:0] ZERO_CHAR = 8'h30;
  localparam logic [7:0] ALPHA_OFS = 8'h57;  // 'a' - 10

  // Fixed slot layout of one burst: d3 d2 d1 d0 CR LF data CR LF.
  // A close reuses it as: slot 3 '0', CR LF, CR LF in slots 4..7.
  localparam int unsigned NUM_SLOTS        = 9;
  localparam logic [3:0]  SLOT_DIG3        = 4'd0;
  localparam logic [3:0]  SLOT_DIG2        = 4'd1;
  localparam logic [3:0]  SLOT_DIG1        = 4'd2;
  localparam logic [3:0]  SLOT_DIG0        = 4'd3;
  localparam logic [3:0]  SLOT_DATA        = 4'd6;
  localparam logic [3:0]  SLOT_CLOSE_LAST  = 4'd7;
  localparam logic [3:0]  SLOT_TRL_LAST    = 4'd8;

  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_CLOSE = 1'b1;

  typedef logic [NUM_SLOTS-1:0][7:0] slot_vec_t;

  typedef struct packed {
    logic       emit;   // item causes at least one byte
    slot_vec_t  slots;
    logic [3:0] first;
    logic [3:0] last;
  } burst_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return ZERO_CHAR + {4'h0, nib};
    end else begin
      return ALPHA_OFS + {4'h0, nib};
    end
  endfunction

endpackage

@@ hdl/hce_framer.sv @@
// Framer: write and chunk counters, builds the byte burst for one input word.
// Depends on hce_pkg.
module hce_framer
  import hce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  input  logic [30:0] write_length,
  output burst_t      burst
);

  logic [30:0] wr_rem_r, wr_rem_nxt;
  logic [15:0] ch_rem_r, ch_rem_nxt;

  logic [30:0] wr_cur;
  logic [15:0] ch_cur;
  logic        hdr;
  logic [15:0] chunk_len;
  logic [15:0] ch_left;
  logic [15:0] ch_after;
  logic        trl;
  logic [15:0] hex_v;
  logic        is_close;
  logic [3:0]  hdr_first;

  assign is_close = (req_type == REQ_CLOSE);

  // A new write's length is only taken when none is in progress
  assign wr_cur    = (wr_rem_r == 31'd0) ? write_length : wr_rem_r;
  assign ch_cur    = (wr_rem_r == 31'd0) ? 16'd0 : ch_rem_r;
  assign hdr       = (ch_cur == 16'd0);
  assign chunk_len = (wr_cur < {15'd0, MAX_CHUNK}) ? wr_cur[15:0] : MAX_CHUNK;
  assign ch_left   = hdr ? chunk_len : ch_cur;
  assign ch_after  = ch_left - 16'd1;
  assign trl       = (ch_after == 16'd0);
  assign hex_v     = is_close ? 16'd0 : chunk_len;

  // no leading zeros: start at the highest non-zero nibble
  always_comb begin
    if (hex_v[15:12] != 4'd0) begin
      hdr_first = SLOT_DIG3;
    end else if (hex_v[11:8] != 4'd0) begin
      hdr_first = SLOT_DIG2;
    end else if (hex_v[7:4] != 4'd0) begin
      hdr_first = SLOT_DIG1;
    end else begin
      hdr_first = SLOT_DIG0;
    end
  end

  always_comb begin
    burst.emit     = is_close || (wr_cur != 31'd0);
    burst.slots[0] = hex_char(hex_v[15:12]);
    burst.slots[1] = hex_char(hex_v[11:8]);
    burst.slots[2] = hex_char(hex_v[7:4]);
    burst.slots[3] = hex_char(hex_v[3:0]);
    burst.slots[4] = CR_BYTE;
    burst.slots[5] = LF_BYTE;
    burst.slots[6] = is_close ? CR_BYTE : data_byte;
    burst.slots[7] = is_close ? LF_BYTE : CR_BYTE;
    burst.slots[8] = LF_BYTE;
    if (is_close) begin
      burst.first = SLOT_DIG0;
      burst.last  = SLOT_CLOSE_LAST;
    end else begin
      burst.first = hdr ? hdr_first : SLOT_DATA;
      burst.last  = trl ? SLOT_TRL_LAST : SLOT_DATA;
    end
  end

  always_comb begin
    wr_rem_nxt = wr_rem_r;
    ch_rem_nxt = ch_rem_r;
    if (accept) begin
      if (is_close) begin
        wr_rem_nxt = 31'd0;
        ch_rem_nxt = 16'd0;
      end else if (wr_cur != 31'd0) begin
        wr_rem_nxt = wr_cur - 31'd1;
        ch_rem_nxt = ch_after;
      end else begin
        wr_rem_nxt = 31'd0;
        ch_rem_nxt = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_rem_r <= 31'd0;
      ch_rem_r <= 16'd0;
    end else begin
      wr_rem_r <= wr_rem_nxt;
      ch_rem_r <= ch_rem_nxt;
    end
  end

endmodule

@@ hdl/hce_serialiser.sv @@
// Serialiser: holds one burst and hands out a byte per cycle unless stalled.
// Depends on hce_pkg.
module hce_serialiser
  import hce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  burst_t     burst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic       busy_r, busy_nxt;
  slot_vec_t  slots_r, slots_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [3:0] last_r, last_nxt;

  logic out_take;
  logic finishing;
  logic load;

  assign out_valid = busy_r;
  assign out_byte  = slots_r[idx_r];
  assign out_last  = (idx_r == last_r);

  assign out_take  = busy_r && !out_stall;
  assign finishing = out_take && out_last;
  // a new word may enter while the final byte of the current burst leaves
  assign in_stall  = busy_r && !finishing;
  assign load      = in_valid && !in_stall && burst.emit;

  always_comb begin
    busy_nxt  = busy_r;
    slots_nxt = slots_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    if (load) begin
      busy_nxt  = 1'b1;
      slots_nxt = burst.slots;
      idx_nxt   = burst.first;
      last_nxt  = burst.last;
    end else if (finishing) begin
      busy_nxt = 1'b0;
    end else if (out_take) begin
      idx_nxt = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slots_r <= slots_nxt;
    idx_r   <= idx_nxt;
    last_r  <= last_nxt;
  end

endmodule

@@ hdl/http_chunked_encoder_unit.sv @@
// HTTP chunked transfer encoder, top level.
// Depends on hce_pkg, hce_framer and hce_serialiser.
//
// Input channel (in_valid / in_stall): one word is either a payload byte of
// the current write (in_req_type = 0) or a close request (in_req_type = 1).
// in_write_length is sampled only with a payload byte that arrives while no
// write is in progress; a zero length there drops the byte with no output.
// Output channel (out_valid / out_stall): the encoded stream, a byte per word,
// with out_last marking the final byte caused by one input word.
// The first byte of a word's burst appears the cycle after the word is
// accepted. While the receiver does not stall, plain payload bytes flow at
// one per cycle; a chunk header or trailer adds bytes to the burst, and a
// close is the five bytes '0' CR LF CR LF.
// The next input word is taken in the cycle the last byte of the current
// burst is taken. While the receiver stalls, the output byte holds and
// in_stall rises once that burst cannot finish. Reset clears both counters
// and empties the output register.
module http_chunked_encoder_unit
  import hce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic [30:0] in_write_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  burst_t burst;
  logic   accept;

  assign accept = in_valid && !in_stall;

  hce_framer u_framer (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .req_type     (in_req_type),
    .data_byte    (in_data_byte),
    .write_length (in_write_length),
    .burst        (burst)
  );

  hce_serialiser u_serialiser (
    .clk       (clk),
    .rst_n     (rst_n),
    .burst     (burst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

@@ hdl/hce_checker.sv @@
// Port-level checks for the chunked encoder, bound to the top level.
// Depends on http_chunked_encoder_unit only through its ports.
module hce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_req_type,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_last
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output word changed under stall");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a burst is never broken off before its last byte
  a_burst_whole: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("burst ended without last byte");

  // a close taken with the output idle starts with the '0' of the terminator
  a_close_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_req_type && !out_valid
      |=> out_valid && out_byte == 8'h30 && !out_last)
    else $error("terminator does not start with '0'");

  // no new word is taken while a burst still has bytes to go
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken mid-burst");

endmodule

bind http_chunked_encoder_unit hce_checker u_hce_checker (.*);
